### sv/via_pkg.sv
// via_pkg: shared types and constants for the via register interface
// register numbers, function codes, interrupt flag bits and the result record
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package via_pkg;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_RAISE = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  localparam logic [3:0] REG_ORB  = 4'h0;
  localparam logic [3:0] REG_ORA  = 4'h1;
  localparam logic [3:0] REG_DDRB = 4'h2;
  localparam logic [3:0] REG_DDRA = 4'h3;
  localparam logic [3:0] REG_T1CL = 4'h4;
  localparam logic [3:0] REG_T1CH = 4'h5;
  localparam logic [3:0] REG_T1LL = 4'h6;
  localparam logic [3:0] REG_T1LH = 4'h7;
  localparam logic [3:0] REG_T2CL = 4'h8;
  localparam logic [3:0] REG_T2CH = 4'h9;
  localparam logic [3:0] REG_SR   = 4'hA;
  localparam logic [3:0] REG_ACR  = 4'hB;
  localparam logic [3:0] REG_PCR  = 4'hC;
  localparam logic [3:0] REG_IFR  = 4'hD;
  localparam logic [3:0] REG_IER  = 4'hE;
  localparam logic [3:0] REG_ORA2 = 4'hF;

  localparam int FLAG_CA2 = 0;
  localparam int FLAG_CA1 = 1;
  localparam int FLAG_SR  = 2;
  localparam int FLAG_CB2 = 3;
  localparam int FLAG_CB1 = 4;
  localparam int FLAG_T2  = 5;
  localparam int FLAG_T1  = 6;

  localparam logic [7:0] PCR_CB2_MASK = 8'hA0;
  localparam logic [7:0] PCR_CB2_IND  = 8'h20;
  localparam logic [7:0] PCR_CA2_MASK = 8'h0A;
  localparam logic [7:0] PCR_CA2_IND  = 8'h02;

  typedef struct packed {
    logic        pb7_out;
    logic        t2_load;
    logic [15:0] t1_latch_value;
    logic        t1_load;
    logic        irq;
    logic [7:0]  read_data;
  } result_t;

endpackage

`default_nettype wire

### sv/via_register_interface.sv
// via_register_interface: bus-facing register file of a 6522-style adapter
// result is registered in the output register, or in the skid if output stalls
// throughput: one transaction per cycle while skid is empty, single decode stage
// a two-entry output (register plus skid) keeps input open while a result waits
// reset: synchronous rst sets valid flags and regfile to their power-up values
// depends on via_pkg and via_regfile
`timescale 1ns / 1ps
`default_nettype none

module via_register_interface (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // reg_sel[3:0], write_data[11:4], raise_flags[18:12], t1_count[34:19], zero fill
  input  wire logic [39:0] s_axis_tdata,
  // func[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // read_data[7:0], irq[8], t1_load[9], t1_latch_value[25:10], t2_load[26],
  // pb7_out[27], zero fill
  output logic [31:0]      m_axis_tdata
);
  import via_pkg::*;

  logic    accept;
  result_t result;
  result_t out_data, skid_data;
  logic    out_valid, skid_valid;

  assign s_axis_tready = ~skid_valid;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'h0, out_data};

  via_regfile u_regfile (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .func        (func_t'(s_axis_tuser)),
    .reg_sel     (s_axis_tdata[3:0]),
    .write_data  (s_axis_tdata[11:4]),
    .raise_flags (s_axis_tdata[18:12]),
    .t1_count    (s_axis_tdata[34:19]),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_data  <= result;
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_data  <= result;
      skid_valid <= 1'b1;
    end
  end

endmodule

`default_nettype wire

### sv/via_regfile.sv
// via_regfile: register state of the via and the decode of one transaction
// read data uses the state before the access, the rest of the result the state after; depends on via_pkg
`timescale 1ns / 1ps
`default_nettype none

module via_regfile (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire via_pkg::func_t   func,
  input  wire logic [3:0]       reg_sel,
  input  wire logic [7:0]       write_data,
  input  wire logic [6:0]       raise_flags,
  input  wire logic [15:0]      t1_count,
  output via_pkg::result_t      result
);
  import via_pkg::*;

  logic [7:0]  port_a_out, port_b_out, port_a_dir, port_b_dir;
  logic [15:0] timer1_latch;
  logic [7:0]  timer2_latch_low;
  logic [15:0] timer2_counter;
  logic [7:0]  shift_reg, aux_control, periph_control;
  logic [6:0]  irq_flags, irq_enables;
  logic        pb7_level;

  logic [7:0]  port_a_out_next, port_b_out_next, port_a_dir_next, port_b_dir_next;
  logic [15:0] timer1_latch_next;
  logic [7:0]  timer2_latch_low_next;
  logic [15:0] timer2_counter_next;
  logic [7:0]  shift_reg_next, aux_control_next, periph_control_next;
  logic [6:0]  irq_flags_next, irq_enables_next;
  logic        pb7_level_next;
  logic [7:0]  rd;
  logic        t1l, t2l;
  logic [15:0] t1_latch_hi;

  always_comb begin
    port_a_out_next       = port_a_out;
    port_b_out_next       = port_b_out;
    port_a_dir_next       = port_a_dir;
    port_b_dir_next       = port_b_dir;
    timer1_latch_next     = timer1_latch;
    timer2_latch_low_next = timer2_latch_low;
    timer2_counter_next   = timer2_counter;
    shift_reg_next        = shift_reg;
    aux_control_next      = aux_control;
    periph_control_next   = periph_control;
    irq_flags_next        = irq_flags;
    irq_enables_next      = irq_enables;
    pb7_level_next        = pb7_level;
    rd                    = 8'h00;
    t1l                   = 1'b0;
    t2l                   = 1'b0;
    t1_latch_hi           = {write_data, timer1_latch[7:0]};
    case (func)
      FUNC_READ: begin
        case (reg_sel)
          REG_ORB: begin
            if ((periph_control & PCR_CB2_MASK) != PCR_CB2_IND)
              irq_flags_next[FLAG_CB2] = 1'b0;
            irq_flags_next[FLAG_CB1] = 1'b0;
            rd = ((port_b_out | ~port_b_dir) & ~{aux_control[7], 7'h00})
                 | {pb7_level, 7'h00};
          end
          REG_DDRB: rd = port_b_dir;
          REG_DDRA: rd = port_a_dir;
          REG_T1CL: begin
            irq_flags_next[FLAG_T1] = 1'b0;
            rd = t1_count[7:0];
          end
          REG_T1CH: rd = t1_count[15:8];
          REG_T1LL: rd = timer1_latch[7:0];
          REG_T1LH: rd = timer1_latch[15:8];
          REG_T2CL: begin
            irq_flags_next[FLAG_T2] = 1'b0;
            if (aux_control[5] && (timer2_counter[7:0] != 8'h00))
              rd = timer2_counter[7:0] - 8'd1;
            else
              rd = timer2_counter[7:0];
          end
          REG_T2CH: rd = timer2_counter[15:8];
          REG_SR: begin
            irq_flags_next[FLAG_SR] = 1'b0;
            rd = shift_reg;
          end
          REG_ACR: rd = aux_control;
          REG_PCR: rd = periph_control;
          REG_IFR: rd = {|(irq_flags & irq_enables), irq_flags};
          REG_IER: rd = {1'b1, irq_enables};
          default: begin
            if ((periph_control & PCR_CA2_MASK) != PCR_CA2_IND)
              irq_flags_next[FLAG_CA2] = 1'b0;
            irq_flags_next[FLAG_CA1] = 1'b0;
            rd = port_a_out | ~port_a_dir;
          end
        endcase
      end
      FUNC_WRITE: begin
        case (reg_sel)
          REG_ORB: port_b_out_next = write_data;
          REG_ORA, REG_ORA2: begin
            irq_flags_next[FLAG_CA1] = 1'b0;
            port_a_out_next = write_data;
          end
          REG_DDRB: port_b_dir_next = write_data;
          REG_DDRA: port_a_dir_next = write_data;
          REG_T1CL, REG_T1LL: timer1_latch_next = {timer1_latch[15:8], write_data};
          REG_T1CH: begin
            timer1_latch_next = t1_latch_hi;
            t1l = 1'b1;
            if (aux_control[7] && (t1_latch_hi > 16'd1))
              pb7_level_next = ~pb7_level;
            irq_flags_next[FLAG_T1] = 1'b0;
          end
          REG_T1LH: begin
            timer1_latch_next = t1_latch_hi;
            irq_flags_next[FLAG_T1] = 1'b0;
          end
          REG_T2CL: timer2_latch_low_next = write_data;
          REG_T2CH: begin
            timer2_counter_next = {write_data, timer2_latch_low};
            t2l = 1'b1;
            irq_flags_next[FLAG_T2] = 1'b0;
          end
          REG_SR: shift_reg_next = write_data;
          REG_ACR: begin
            aux_control_next = write_data;
            if (write_data[7])
              pb7_level_next = 1'b1;
          end
          REG_PCR: periph_control_next = write_data;
          REG_IFR: irq_flags_next = irq_flags & ~write_data[6:0];
          default: begin
            if (write_data[7])
              irq_enables_next = irq_enables | write_data[6:0];
            else
              irq_enables_next = irq_enables & ~write_data[6:0];
          end
        endcase
      end
      FUNC_RAISE: irq_flags_next = irq_flags | raise_flags;
      default: ;
    endcase

    result.read_data      = rd;
    result.irq            = |(irq_flags_next & irq_enables_next);
    result.t1_load        = t1l;
    result.t1_latch_value = timer1_latch_next;
    result.t2_load        = t2l;
    result.pb7_out        = pb7_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_a_out       <= 8'h00;
      port_b_out       <= 8'h00;
      port_a_dir       <= 8'h00;
      port_b_dir       <= 8'h00;
      timer1_latch     <= 16'hFFFF;
      timer2_latch_low <= 8'hFF;
      timer2_counter   <= 16'hFFFF;
      shift_reg        <= 8'h00;
      aux_control      <= 8'h00;
      periph_control   <= 8'h00;
      irq_flags        <= 7'h00;
      irq_enables      <= 7'h00;
      pb7_level        <= 1'b0;
    end else if (accept) begin
      port_a_out       <= port_a_out_next;
      port_b_out       <= port_b_out_next;
      port_a_dir       <= port_a_dir_next;
      port_b_dir       <= port_b_dir_next;
      timer1_latch     <= timer1_latch_next;
      timer2_latch_low <= timer2_latch_low_next;
      timer2_counter   <= timer2_counter_next;
      shift_reg        <= shift_reg_next;
      aux_control      <= aux_control_next;
      periph_control   <= periph_control_next;
      irq_flags        <= irq_flags_next;
      irq_enables      <= irq_enables_next;
      pb7_level        <= pb7_level_next;
    end
  end

endmodule

`default_nettype wire
